FILE: rtl/fsnc_pkg.sv
// Shared types and constants for the approximate single-precision square root core.
`default_nettype none
package fsnc_pkg;

   localparam logic [31:0] GUESS_MAGIC = 32'h1fbb67ae;
   localparam logic [31:0] LOW_NORMAL  = 32'h00800000;
   localparam logic [31:0] EXP_ALL_ONE = 32'h7f800000;

   // Operand of the divider as it moves through the digit-recurrence stages.
   typedef struct packed {
      logic        valid;
      logic        ok;
      logic [31:0] guess;
      logic [24:0] quo;
      logic [24:0] rem;
      logic [23:0] den;
      logic [7:0]  exp;
   } div_type;

endpackage
`default_nettype wire

FILE: rtl/fsnc_div_stage.sv
// One registered stage of the restoring divider, STEPS quotient bits per stage.
`default_nettype none
module fsnc_div_stage #(
   parameter int STEPS = 6
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 enable,
   input  fsnc_pkg::div_type   stage_in,
   output fsnc_pkg::div_type   stage_out
);
   import fsnc_pkg::*;

   div_type stage_ff;
   div_type stage_in_w;

   always_comb begin
      logic [24:0] rem;
      logic [24:0] quo;
      logic        ge;
      stage_in_w = stage_in;
      rem = stage_in.rem;
      quo = stage_in.quo;
      for (int i = 0; i < STEPS; i++) begin
         ge = (rem >= {1'b0, stage_in.den});
         if (ge) begin
            rem = rem - {1'b0, stage_in.den};
         end
         quo = {quo[23:0], ge};
         rem = {rem[23:0], 1'b0};
      end
      stage_in_w.rem = rem;
      stage_in_w.quo = quo;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (enable) begin
         stage_ff.valid <= stage_in_w.valid;
      end
      if (enable) begin
         stage_ff.ok    <= stage_in_w.ok;
         stage_ff.guess <= stage_in_w.guess;
         stage_ff.quo   <= stage_in_w.quo;
         stage_ff.rem   <= stage_in_w.rem;
         stage_ff.den   <= stage_in_w.den;
         stage_ff.exp   <= stage_in_w.exp;
      end
   end

   assign stage_out = stage_ff;

endmodule
`default_nettype wire

FILE: rtl/fast_float_sqrt_newton_core.sv
// Top level: bit-hack first guess, one Newton step, as an eight-stage pipeline.
//
//   channel   direction   beat contents
//   req_      in          tdata[31:0] value_bits
//   rsp_      out         tdata[31:0] root_bits, tuser[0] in_range
//
// One beat is taken every cycle while the output moves.
// Stages: guess and unpack, four divider stages (7, 6, 6, 6 quotient bits),
// quotient rounding, alignment and add, then add rounding with the halving.
// Reset clears only the valid bits. A stall on rsp_ freezes every stage at once.
`default_nettype none
module fast_float_sqrt_newton_core (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [31:0] req_tdata,   // [31:0] value_bits
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] root_bits
   output logic [0:0]  rsp_tuser    // [0] in_range
);
   import fsnc_pkg::*;

   logic adv;
   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;

   // Stage 1: guess, mantissa compare and quotient exponent.
   div_type s1_in, s1_ff, s2, s3, s4, s5;

   always_comb begin
      logic [31:0] gb;
      logic [23:0] ma;
      logic        lt;
      logic [9:0]  e;
      gb = (req_tdata >> 1) + GUESS_MAGIC;
      ma = {1'b1, req_tdata[22:0]};
      s1_in.valid = req_tvalid;
      s1_in.ok    = (req_tdata >= LOW_NORMAL) && (req_tdata < EXP_ALL_ONE);
      s1_in.guess = gb;
      s1_in.den   = {1'b1, gb[22:0]};
      lt          = ma < s1_in.den;
      s1_in.rem   = lt ? {ma, 1'b0} : {1'b0, ma};
      s1_in.quo   = '0;
      e = {2'b0, req_tdata[30:23]} - {2'b0, gb[30:23]} + 10'd127 - {9'b0, lt};
      s1_in.exp   = e[7:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.valid <= 1'b0;
      end else if (adv) begin
         s1_ff.valid <= s1_in.valid;
      end
      if (adv) begin
         s1_ff.ok    <= s1_in.ok;
         s1_ff.guess <= s1_in.guess;
         s1_ff.quo   <= s1_in.quo;
         s1_ff.rem   <= s1_in.rem;
         s1_ff.den   <= s1_in.den;
         s1_ff.exp   <= s1_in.exp;
      end
   end

   fsnc_div_stage #(.STEPS(7)) u_div0 (.clock(clock), .reset(reset), .enable(adv),
      .stage_in(s1_ff), .stage_out(s2));
   fsnc_div_stage #(.STEPS(6)) u_div1 (.clock(clock), .reset(reset), .enable(adv),
      .stage_in(s2), .stage_out(s3));
   fsnc_div_stage #(.STEPS(6)) u_div2 (.clock(clock), .reset(reset), .enable(adv),
      .stage_in(s3), .stage_out(s4));
   fsnc_div_stage #(.STEPS(6)) u_div3 (.clock(clock), .reset(reset), .enable(adv),
      .stage_in(s4), .stage_out(s5));

   // Stage 6: round the quotient to nearest even.
   logic        s6_valid_ff, s6_ok_ff;
   logic [31:0] s6_guess_ff, s6_quo_ff;
   logic [31:0] s6_quo_in;

   always_comb begin
      logic        up;
      logic [24:0] m;
      logic [7:0]  e;
      up = s5.quo[0] && ((s5.rem != '0) || s5.quo[1]);
      m  = {1'b0, s5.quo[24:1]} + {24'b0, up};
      e  = s5.exp + {7'b0, m[24]};
      s6_quo_in = {1'b0, e, m[24] ? 23'b0 : m[22:0]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_valid_ff <= 1'b0;
      end else if (adv) begin
         s6_valid_ff <= s5.valid;
      end
      if (adv) begin
         s6_ok_ff    <= s5.ok;
         s6_guess_ff <= s5.guess;
         s6_quo_ff   <= s6_quo_in;
      end
   end

   // Stage 7: align the smaller addend and add exactly.
   logic        s7_valid_ff, s7_ok_ff;
   logic [48:0] s7_sum_ff, s7_sum_in;
   logic [7:0]  s7_exp_ff, s7_exp_in;

   always_comb begin
      logic [31:0] a, b;
      logic [7:0]  d;
      logic [47:0] bsh;
      if (s6_guess_ff[30:0] >= s6_quo_ff[30:0]) begin
         a = s6_guess_ff;
         b = s6_quo_ff;
      end else begin
         a = s6_quo_ff;
         b = s6_guess_ff;
      end
      d = a[30:23] - b[30:23];
      // Beyond 24 places the small addend is under half an ulp and drops out.
      if (d > 8'd24) begin
         bsh = '0;
      end else begin
         bsh = {1'b1, b[22:0], 24'b0} >> d;
      end
      s7_sum_in = {1'b0, 1'b1, a[22:0], 24'b0} + {1'b0, bsh};
      s7_exp_in = a[30:23];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s7_valid_ff <= 1'b0;
      end else if (adv) begin
         s7_valid_ff <= s6_valid_ff;
      end
      if (adv) begin
         s7_ok_ff  <= s6_ok_ff;
         s7_sum_ff <= s7_sum_in;
         s7_exp_ff <= s7_exp_in;
      end
   end

   // Stage 8: normalize, round, and halve by taking one off the exponent.
   logic        rsp_valid_ff, rsp_ok_ff;
   logic [31:0] rsp_root_ff, rsp_root_in;

   always_comb begin
      logic [23:0] m;
      logic        g, st, up;
      logic [24:0] mr;
      logic [7:0]  e;
      if (s7_sum_ff[48]) begin
         m  = s7_sum_ff[48:25];
         g  = s7_sum_ff[24];
         st = |s7_sum_ff[23:0];
      end else begin
         m  = s7_sum_ff[47:24];
         g  = s7_sum_ff[23];
         st = |s7_sum_ff[22:0];
      end
      up = g && (st || m[0]);
      mr = {1'b0, m} + {24'b0, up};
      e  = s7_exp_ff + {7'b0, s7_sum_ff[48]} + {7'b0, mr[24]} - 8'd1;
      rsp_root_in = s7_ok_ff ? {1'b0, e, mr[24] ? 23'b0 : mr[22:0]} : 32'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= s7_valid_ff;
      end
      if (adv) begin
         rsp_ok_ff   <= s7_ok_ff;
         rsp_root_ff <= rsp_root_in;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_root_ff;
   assign rsp_tuser[0] = rsp_ok_ff;

endmodule
`default_nettype wire

FILE: test/fast_float_sqrt_newton_core_tb.sv
// Testbench for the approximate square root core: random and corner operands against a predictor.
`default_nettype none
module fast_float_sqrt_newton_core_tb;
   import fsnc_pkg::*;

   typedef struct {
      logic [31:0] root;
      logic        ok;
   } root_beat_type;

   // Rounds a double to the nearest single, ties to even; operands here are normal.
   function automatic logic [31:0] round_to_single(real r);
      logic [63:0] d;
      logic [24:0] mant;
      logic [28:0] rest;
      logic [7:0]  ex;
      d    = $realtobits(r);
      ex   = 8'(d[62:52] - 11'd896);
      mant = {2'b01, d[51:29]};
      rest = d[28:0];
      if (rest > 29'h1000_0000 || (rest == 29'h1000_0000 && mant[0])) mant = mant + 25'd1;
      if (mant[24]) begin
         mant = mant >> 1;
         ex   = ex + 8'd1;
      end
      return {d[63], ex, mant[22:0]};
   endfunction

   function automatic real single_to_real(logic [31:0] s);
      return $bitstoreal({s[31], 11'(s[30:23]) + 11'd896, s[22:0], 29'd0});
   endfunction

   function automatic root_beat_type predict_root(logic [31:0] x);
      root_beat_type b;
      logic [31:0]   guess, quo, total;
      if (x >= LOW_NORMAL && x < EXP_ALL_ONE) begin
         guess  = (x >> 1) + GUESS_MAGIC;
         quo    = round_to_single(single_to_real(x) / single_to_real(guess));
         total  = round_to_single(single_to_real(guess) + single_to_real(quo));
         b.root = round_to_single(0.5 * single_to_real(total));
         b.ok   = 1'b1;
      end else begin
         b.root = '0;
         b.ok   = 1'b0;
      end
      return b;
   endfunction

   class root_ledger_type;
      root_beat_type pending[$];
      int            errors = 0;
      int            matched = 0;
      int            in_range_seen = 0;

      function void note_operand(logic [31:0] x);
         pending.push_back(predict_root(x));
      endfunction

      function void check_root(logic [31:0] root, logic ok);
         root_beat_type e;
         if (pending.size() == 0) begin
            $display("%0t: unexpected beat root=%h in_range=%b", $time, root, ok);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (root !== e.root) begin
            $display("%0t: root_bits expected %h actual %h", $time, e.root, root);
            errors++;
         end
         if (ok !== e.ok) begin
            $display("%0t: in_range expected %b actual %b", $time, e.ok, ok);
            errors++;
         end
         matched++;
         if (e.ok) in_range_seen++;
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic [31:0] req_tdata = '0;
   logic        rsp_tready = 1'b0;
   wire         req_tready;
   wire         rsp_tvalid;
   wire  [31:0] rsp_tdata;
   wire  [0:0]  rsp_tuser;

   root_ledger_type ledger = new();
   int  sent = 0;
   bit  calm = 1'b0;
   bit  hold = 1'b0;
   bit  done = 1'b0;

   fast_float_sqrt_newton_core u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) ledger.check_root(rsp_tdata, rsp_tuser[0]);
         rsp_tready <= hold ? 1'b0 : (calm || $urandom_range(99) >= 31);
      end
   end

   task automatic send_operand(logic [31:0] x);
      while (!calm && $urandom_range(99) < 31) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= x;
      do @(posedge clock); while (!req_tready);
      ledger.note_operand(x);
      sent++;
   endtask

   // Receiver backpressure long enough for the pipeline to fill and stall the input.
   initial begin
      wait (sent >= 120);
      @(posedge clock);
      hold = 1'b1;
      repeat (300) @(posedge clock);
      hold = 1'b0;
   end

   initial begin
      logic [31:0] corners[16];
      corners = '{
         32'h0000_0000, 32'h0080_0000, 32'h007f_ffff, 32'h7f7f_ffff,
         32'h7f80_0000, 32'h7fc0_0000, 32'h8000_0000, 32'hff80_0000,
         32'h3f80_0000, 32'h4080_0000, 32'h0080_0001, 32'h8080_0000,
         32'h7f7f_fffe, 32'h3f7f_ffff, 32'h00ff_ffff, 32'hffff_ffff};
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      foreach (corners[i]) send_operand(corners[i]);
      for (int n = 0; n < 900; n++) begin
         calm = (n >= 400 && n < 520);
         if ($urandom_range(99) < 80) send_operand($urandom_range(32'h7f7f_ffff, 32'h0080_0000));
         else send_operand($urandom);
      end
      calm = 1'b0;
      req_tvalid <= 1'b0;
      wait (ledger.pending.size() == 0);
      repeat (20) @(posedge clock);
      $display("Sent %0d operands (corners, random normals, random raw patterns).", sent);
      $display("Checked %0d beats, %0d in range, with a long output stall.",
               ledger.matched, ledger.in_range_seen);
      if (ledger.errors == 0 && ledger.pending.size() == 0)
         $display("fast_float_sqrt_newton_core: match");
      else
         $display("fast_float_sqrt_newton_core: mismatch");
      $finish;
   end

   initial begin
      #2000000;
      $display("fast_float_sqrt_newton_core: mismatch");
      $finish;
   end

endmodule
`default_nettype wire
